// ----- src/i2cmbe_pkg.sv -----
// Package for the I2C master bit engine: sizes, input codes and the
// classified item type passed from the front end to the bit engine.
// No dependencies.
`default_nettype none

package i2cmbe_pkg;

	localparam int QUEUE_DEPTH = 8;
	localparam int MAX_BYTES   = 16;
	localparam int DATA_DEPTH  = 16;

	localparam int DQ_AW  = $clog2(QUEUE_DEPTH);
	localparam int DQ_CW  = $clog2(QUEUE_DEPTH + 1);
	localparam int WQ_AW  = $clog2(DATA_DEPTH);
	localparam int WQ_CW  = $clog2(DATA_DEPTH + 1);
	localparam int LEN_W  = $clog2(MAX_BYTES + 1);
	localparam int LEN_IN_W = 5;

	localparam int IQ_DEPTH = 2;
	localparam int IQ_AW    = $clog2(IQ_DEPTH);
	localparam int IQ_CW    = $clog2(IQ_DEPTH + 1);

	localparam logic [1:0] KIND_TICK = 2'd0;
	localparam logic [1:0] KIND_DESC = 2'd1;
	localparam logic [1:0] KIND_DATA = 2'd2;

	localparam int RW_BIT = 0;
	localparam int MSB_BIT = 7;
	localparam logic [3:0] BITS_PER_BYTE = 4'd8;
	localparam logic [7:0] IDLE_BYTE = 8'hFF;

	typedef struct packed {
		logic             is_tick;
		logic             is_desc;
		logic             is_data;
		logic             sda;
		logic [7:0]       addr_rw;
		logic [LEN_W-1:0] len;
		logic [7:0]       wbyte;
	} item_t;

endpackage

`default_nettype wire

// ----- src/i2cmbe_in_if.sv -----
// Input channel of the I2C master bit engine: valid/ready plus item fields.
// No dependencies.
`default_nettype none

interface i2cmbe_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic       sda_in;
	logic [7:0] addr_rw;
	logic [4:0] transfer_length;
	logic [7:0] write_byte;

	modport source (output valid, kind, sda_in, addr_rw, transfer_length, write_byte,
		input ready);
	modport sink (input valid, kind, sda_in, addr_rw, transfer_length, write_byte,
		output ready);
endinterface

`default_nettype wire

// ----- src/i2cmbe_out_if.sv -----
// Result channel of the I2C master bit engine: valid/ready plus result fields.
// No dependencies.
`default_nettype none

interface i2cmbe_out_if;
	logic       valid;
	logic       ready;
	logic       scl_out;
	logic       sda_out;
	logic       accepted;
	logic [7:0] read_data;
	logic       read_valid;
	logic       read_last;
	logic       transfer_done;
	logic       nack_error;
	logic       busy_res;

	modport source (output valid, scl_out, sda_out, accepted, read_data, read_valid,
		read_last, transfer_done, nack_error, busy_res, input ready);
	modport sink (input valid, scl_out, sda_out, accepted, read_data, read_valid,
		read_last, transfer_done, nack_error, busy_res, output ready);
endinterface

`default_nettype wire

// ----- src/i2c_master_bit_engine_core.sv -----
// Top level of the I2C master bit engine: front end, item queue and bit engine.
// Depends on i2cmbe_pkg, the channel interfaces and the three submodules.
//
// Usage:
//   items   : input channel. kind selects a tick (with the sampled SDA level),
//             a transfer descriptor (addr_rw, transfer_length) or a write byte.
//   results : one transaction per input transaction, in order: line levels
//             after the item, accepted flag for queue items, read byte strobes,
//             transfer done and NACK flags, and the busy flag.
//   Path    : an accepted input passes through the front register, the item
//             queue and the result register, in that order, before its result
//             is offered.
//   Throughput: one item per cycle while results is not stalled; the bit
//             engine runs one half-bit step or one queue write per cycle.
//   Stall   : while results is stalled the result register holds; the front
//             register and the two-entry item queue keep taking input until
//             full, then items.ready drops.
//   Reset   : arst_n clears all control state; the engine comes up idle with
//             SCL and SDA released high and both queues empty.
`default_nettype none

module i2c_master_bit_engine_core import i2cmbe_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	i2cmbe_in_if.sink    items,
	i2cmbe_out_if.source results
);

	logic  push;
	item_t push_item;
	logic  q_full;
	logic  q_valid;
	item_t q_item;
	logic  q_pop;

	i2cmbe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (items),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	i2cmbe_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.pop        (q_pop),
		.full       (q_full),
		.head_valid (q_valid),
		.head_item  (q_item)
	);

	i2cmbe_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop),
		.results (results)
	);

endmodule

`default_nettype wire

// ----- src/i2cmbe_front.sv -----
// Front end: registers incoming transactions, decodes the kind and clamps the
// transfer length. Depends on i2cmbe_pkg and i2cmbe_in_if.
`default_nettype none

module i2cmbe_front import i2cmbe_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	i2cmbe_in_if.sink   items,
	input  wire logic   q_full,
	output logic        push,
	output item_t       push_item
);

	logic  valid_s1;
	item_t item_s1;
	item_t item_dec;
	logic  fire;

	always_comb begin
		item_dec.is_tick = (items.kind == KIND_TICK);
		item_dec.is_desc = (items.kind == KIND_DESC);
		item_dec.is_data = (items.kind == KIND_DATA);
		item_dec.sda     = items.sda_in;
		item_dec.addr_rw = items.addr_rw;
		item_dec.wbyte   = items.write_byte;
		priority if (items.transfer_length == '0) begin
			item_dec.len = LEN_W'(1);
		end else if (9'(items.transfer_length) > 9'(MAX_BYTES)) begin
			item_dec.len = LEN_W'(MAX_BYTES);
		end else begin
			item_dec.len = LEN_W'(items.transfer_length);
		end
	end

	assign items.ready = !valid_s1 || !q_full;
	assign fire        = items.valid && items.ready;
	assign push        = valid_s1 && !q_full;
	assign push_item   = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (fire) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			item_s1 <= item_dec;
		end
	end

endmodule

`default_nettype wire

// ----- src/i2cmbe_queue.sv -----
// Short queue of classified items between the front end and the bit engine.
// Depends on i2cmbe_pkg.
`default_nettype none

module i2cmbe_queue import i2cmbe_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire item_t  push_item,
	input  wire logic   pop,
	output logic        full,
	output logic        head_valid,
	output item_t       head_item
);

	item_t            slots_q [IQ_DEPTH];
	logic [IQ_AW-1:0] rd_q;
	logic [IQ_AW-1:0] wr_q;
	logic [IQ_CW-1:0] cnt_q;

	function automatic logic [IQ_AW-1:0] step(input logic [IQ_AW-1:0] p);
		return (p == IQ_AW'(IQ_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full       = (cnt_q == IQ_CW'(IQ_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_item  = slots_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			wr_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= step(wr_q);
			end
			if (pop) begin
				rd_q <= step(rd_q);
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

// ----- src/i2cmbe_back.sv -----
// Bit engine: descriptor and write-byte queues, half-bit state machine and the
// registered result stage. Depends on i2cmbe_pkg and i2cmbe_out_if.
`default_nettype none

module i2cmbe_back import i2cmbe_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   q_valid,
	input  wire item_t  q_item,
	output logic        q_pop,
	i2cmbe_out_if.source results
);

	typedef enum logic [4:0] {
		PH_IDLE, PH_START_L, PH_START_H, PH_ADDR_L, PH_ADDR_H, PH_AACK_L, PH_AACK_H,
		PH_RD_L, PH_RD_H, PH_WR_L, PH_WR_H, PH_MACK_L, PH_MACK_H, PH_WACK_L,
		PH_WACK_H, PH_MNACK_L, PH_MNACK_H, PH_STOP_L, PH_STOP_H
	} phase_t;

	phase_t           phase_q, phase_n;
	logic [3:0]       bits_q, bits_n;
	logic [7:0]       shift_q, shift_n;
	logic [LEN_W-1:0] bdone_q, bdone_n;
	logic [DQ_AW-1:0] dhead_q, dhead_n;
	logic [DQ_CW-1:0] dcount_q, dcount_n;
	logic [WQ_AW-1:0] whead_q, whead_n;
	logic [WQ_CW-1:0] wcount_q, wcount_n;
	logic             scl_q, scl_n;
	logic             sda_q, sda_n;
	logic             out_valid_q;

	logic [7:0]       desc_addr_q [QUEUE_DEPTH];
	logic [LEN_W-1:0] desc_len_q  [QUEUE_DEPTH];
	logic [7:0]       wdata_q     [DATA_DEPTH];

	logic             desc_we, data_we;
	logic [DQ_AW:0]   dsum;
	logic [DQ_AW-1:0] dslot;
	logic [WQ_AW:0]   wsum;
	logic [WQ_AW-1:0] wslot;
	logic [7:0]       haddr;
	logic [LEN_W-1:0] hlen;
	logic [LEN_W-1:0] bd_inc;
	logic [7:0]       tx_byte;
	logic             r_acc, r_rvalid, r_rlast, r_done, r_nack;
	logic [7:0]       r_rdata;

	function automatic logic [DQ_AW-1:0] dstep(input logic [DQ_AW-1:0] p);
		return (p == DQ_AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [WQ_AW-1:0] wstep(input logic [WQ_AW-1:0] p);
		return (p == WQ_AW'(DATA_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_comb begin
		dsum = {1'b0, dhead_q} + (DQ_AW + 1)'(dcount_q);
		if (dsum >= (DQ_AW + 1)'(QUEUE_DEPTH)) begin
			dsum = dsum - (DQ_AW + 1)'(QUEUE_DEPTH);
		end
		dslot = dsum[DQ_AW-1:0];
		wsum = {1'b0, whead_q} + (WQ_AW + 1)'(wcount_q);
		if (wsum >= (WQ_AW + 1)'(DATA_DEPTH)) begin
			wsum = wsum - (WQ_AW + 1)'(DATA_DEPTH);
		end
		wslot = wsum[WQ_AW-1:0];
	end

	assign haddr   = desc_addr_q[dhead_q];
	assign hlen    = desc_len_q[dhead_q];
	assign bd_inc  = bdone_q + 1'b1;
	assign tx_byte = (wcount_q != '0) ? wdata_q[whead_q] : IDLE_BYTE;
	assign q_pop   = q_valid && (!out_valid_q || results.ready);

	always_comb begin
		phase_n  = phase_q;
		bits_n   = bits_q;
		shift_n  = shift_q;
		bdone_n  = bdone_q;
		dhead_n  = dhead_q;
		dcount_n = dcount_q;
		whead_n  = whead_q;
		wcount_n = wcount_q;
		scl_n    = scl_q;
		sda_n    = sda_q;
		desc_we  = 1'b0;
		data_we  = 1'b0;
		r_acc    = 1'b0;
		r_rdata  = '0;
		r_rvalid = 1'b0;
		r_rlast  = 1'b0;
		r_done   = 1'b0;
		r_nack   = 1'b0;
		if (q_pop) begin
			priority if (q_item.is_desc) begin
				if (dcount_q < DQ_CW'(QUEUE_DEPTH)) begin
					desc_we  = 1'b1;
					dcount_n = dcount_q + 1'b1;
					r_acc    = 1'b1;
					if (phase_q == PH_IDLE) begin
						phase_n = PH_START_L;
						scl_n   = 1'b1;
						sda_n   = 1'b1;
					end
				end
			end else if (q_item.is_data) begin
				if (wcount_q < WQ_CW'(DATA_DEPTH)) begin
					data_we  = 1'b1;
					wcount_n = wcount_q + 1'b1;
					r_acc    = 1'b1;
				end
			end else if (q_item.is_tick) begin
				scl_n = !scl_q;
				unique case (phase_q)
					PH_START_L: begin
						shift_n = haddr;
						bits_n  = BITS_PER_BYTE;
						bdone_n = '0;
						sda_n   = 1'b1;
						phase_n = PH_START_H;
					end
					PH_START_H: begin
						sda_n   = 1'b0;
						phase_n = PH_ADDR_L;
					end
					PH_ADDR_L, PH_WR_L: begin
						if (phase_q == PH_WR_L && bits_q == BITS_PER_BYTE) begin
							shift_n = tx_byte;
							if (wcount_q != '0) begin
								whead_n  = wstep(whead_q);
								wcount_n = wcount_q - 1'b1;
							end
						end
						sda_n = shift_n[MSB_BIT];
						if (bits_q != '0) begin
							bits_n = bits_q - 1'b1;
						end
						phase_n = (phase_q == PH_ADDR_L) ? PH_ADDR_H : PH_WR_H;
					end
					PH_ADDR_H, PH_WR_H: begin
						if (bits_q == '0) begin
							bits_n  = BITS_PER_BYTE;
							phase_n = (phase_q == PH_ADDR_H) ? PH_AACK_L : PH_WACK_L;
						end else begin
							shift_n = {shift_q[6:0], 1'b0};
							phase_n = (phase_q == PH_ADDR_H) ? PH_ADDR_L : PH_WR_L;
						end
					end
					PH_AACK_L, PH_WACK_L: begin
						sda_n   = 1'b1;
						phase_n = (phase_q == PH_AACK_L) ? PH_AACK_H : PH_WACK_H;
					end
					PH_AACK_H: begin
						if (!q_item.sda) begin
							phase_n = haddr[RW_BIT] ? PH_RD_L : PH_WR_L;
						end else begin
							if (dcount_q != '0) begin
								dhead_n  = dstep(dhead_q);
								dcount_n = dcount_q - 1'b1;
							end
							r_nack  = 1'b1;
							phase_n = PH_STOP_L;
						end
					end
					PH_RD_L: begin
						sda_n = 1'b1;
						if (bits_q != '0) begin
							bits_n = bits_q - 1'b1;
						end
						phase_n = PH_RD_H;
					end
					PH_RD_H: begin
						shift_n = {shift_q[6:0], q_item.sda};
						if (bits_q == '0) begin
							bits_n   = BITS_PER_BYTE;
							bdone_n  = bd_inc;
							r_rvalid = 1'b1;
							r_rdata  = shift_n;
							r_rlast  = (bd_inc >= hlen);
							phase_n  = (bd_inc >= hlen) ? PH_MNACK_L : PH_MACK_L;
						end else begin
							phase_n = PH_RD_L;
						end
					end
					PH_MACK_L: begin
						sda_n   = 1'b0;
						phase_n = PH_MACK_H;
					end
					PH_MACK_H: begin
						phase_n = PH_RD_L;
					end
					PH_WACK_H: begin
						if (!q_item.sda) begin
							bdone_n = bd_inc;
							if (bd_inc >= hlen) begin
								if (dcount_q != '0) begin
									dhead_n  = dstep(dhead_q);
									dcount_n = dcount_q - 1'b1;
								end
								r_done  = 1'b1;
								phase_n = (dcount_n != '0) ? PH_START_L : PH_STOP_L;
							end else begin
								phase_n = PH_WR_L;
							end
						end else begin
							if (dcount_q != '0) begin
								dhead_n  = dstep(dhead_q);
								dcount_n = dcount_q - 1'b1;
							end
							r_nack  = 1'b1;
							phase_n = PH_STOP_L;
						end
					end
					PH_MNACK_L: begin
						sda_n   = 1'b1;
						phase_n = PH_MNACK_H;
					end
					PH_MNACK_H: begin
						if (dcount_q != '0) begin
							dhead_n  = dstep(dhead_q);
							dcount_n = dcount_q - 1'b1;
						end
						r_done  = 1'b1;
						phase_n = (dcount_n != '0) ? PH_START_L : PH_STOP_L;
					end
					PH_STOP_L: begin
						sda_n   = 1'b0;
						phase_n = PH_STOP_H;
					end
					PH_STOP_H: begin
						sda_n   = 1'b1;
						phase_n = (dcount_q != '0) ? PH_START_L : PH_IDLE;
					end
					default: begin
						phase_n = PH_IDLE;
						scl_n   = 1'b1;
						sda_n   = 1'b1;
					end
				endcase
			end else begin
				phase_n = phase_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			bits_q      <= BITS_PER_BYTE;
			shift_q     <= '0;
			bdone_q     <= '0;
			dhead_q     <= '0;
			dcount_q    <= '0;
			whead_q     <= '0;
			wcount_q    <= '0;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			phase_q  <= phase_n;
			bits_q   <= bits_n;
			shift_q  <= shift_n;
			bdone_q  <= bdone_n;
			dhead_q  <= dhead_n;
			dcount_q <= dcount_n;
			whead_q  <= whead_n;
			wcount_q <= wcount_n;
			scl_q    <= scl_n;
			sda_q    <= sda_n;
			if (q_pop) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign results.valid = out_valid_q;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			results.scl_out       <= scl_n;
			results.sda_out       <= sda_n;
			results.accepted      <= r_acc;
			results.read_data     <= r_rdata;
			results.read_valid    <= r_rvalid;
			results.read_last     <= r_rlast;
			results.transfer_done <= r_done;
			results.nack_error    <= r_nack;
			results.busy_res      <= (phase_n != PH_IDLE);
		end
	end

	always_ff @(posedge clk) begin
		if (desc_we) begin
			desc_addr_q[dslot] <= q_item.addr_rw;
			desc_len_q[dslot]  <= q_item.len;
		end
		if (data_we) begin
			wdata_q[wslot] <= q_item.wbyte;
		end
	end

endmodule

`default_nettype wire

// ----- src/i2cmbe_checker.sv -----
// Port-level checks for the I2C master bit engine, bound to the top level.
// Depends on i2c_master_bit_engine_core and its channel interfaces.
`default_nettype none

module i2cmbe_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       scl_out,
	input wire logic       sda_out,
	input wire logic       accepted,
	input wire logic       read_valid,
	input wire logic       read_last,
	input wire logic       transfer_done,
	input wire logic       nack_error,
	input wire logic       busy_res
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_idle_lines: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !busy_res |-> scl_out && sda_out)
		else $error("lines not released while idle");

	a_read_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && read_valid |-> busy_res && scl_out && !transfer_done && !nack_error)
		else $error("read strobe outside a read high phase");

	a_queue_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (accepted || read_last) |->
		(accepted ? !read_valid && !transfer_done && !nack_error : read_valid))
		else $error("inconsistent result flags");

endmodule

bind i2c_master_bit_engine_core i2cmbe_checker u_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (results.valid),
	.out_ready     (results.ready),
	.scl_out       (results.scl_out),
	.sda_out       (results.sda_out),
	.accepted      (results.accepted),
	.read_valid    (results.read_valid),
	.read_last     (results.read_last),
	.transfer_done (results.transfer_done),
	.nack_error    (results.nack_error),
	.busy_res      (results.busy_res)
);

`default_nettype wire
